>>> hw/rtl/pli_pkg.sv
// ----------------------------------------------------------------------------
// pli_pkg
// Types and constants for the polyline length and interpolation block.
// ----------------------------------------------------------------------------
`default_nettype none
package pli_pkg;
   localparam int COORD_W = 32;
   localparam int DIST_W  = 40;
   localparam int WHERE_W = 2;

   localparam logic [WHERE_W-1:0] WHERE_BEFORE = 2'd0;
   localparam logic [WHERE_W-1:0] WHERE_ON     = 2'd1;
   localparam logic [WHERE_W-1:0] WHERE_PAST   = 2'd2;

   typedef struct packed {
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic signed [DIST_W-1:0]  target_distance;
      logic                      first_vertex;
      logic                      last_vertex;
   } req_item_type;

   typedef struct packed {
      logic [DIST_W-1:0]         total_length;
      logic signed [COORD_W-1:0] point_x;
      logic signed [COORD_W-1:0] point_y;
      logic [WHERE_W-1:0]        where_found;
   } rsp_item_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_SQUARE, ST_SQRT, ST_MULT, ST_DIV, ST_UPDATE, ST_OUT
   } state_type;

   typedef struct packed {
      logic load;
      logic start_square;
      logic load_square;
      logic sqrt_step;
      logic start_mult;
      logic div_step;
      logic update;
   } cmd_type;

   typedef struct packed {
      logic first;
      logic last;
      logic need_div;
      logic sqrt_done;
      logic div_done;
   } status_type;
endpackage
`default_nettype wire

>>> hw/rtl/polyline_length_and_interpolate.sv
// ----------------------------------------------------------------------------
// polyline_length_and_interpolate
// Polyline length and point at a distance along it.
// ----------------------------------------------------------------------------
// One vertex per req item; first_vertex starts a polyline and samples
// target_distance, last_vertex makes one rsp item carrying total_length,
// the point at that distance and where_found.
// A vertex runs a bit-serial square root of one bit per cycle over
// COORD_W + 2 steps. On the segment that holds the point a shift-add
// multiply and divide of one bit per cycle over both axes together
// follows. A first vertex skips both and only updates the state.
// A new item is taken only once the previous one is finished.
// On a last vertex rsp_valid rises once the vertex has been updated.
// The rsp item holds until rsp_stall is low; req_stall stays high meanwhile.
// Synchronous reset returns the polyline state to zero length at (0,0).
// ----------------------------------------------------------------------------
`default_nettype none
module polyline_length_and_interpolate (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  pli_pkg::req_item_type  req_item,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   output pli_pkg::rsp_item_type  rsp_item
);
   import pli_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       take;

   assign req_stall = !take;

   pli_ctrl u_ctrl (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_take(take),
      .out_valid(rsp_valid), .out_stall(rsp_stall), .status(status), .cmd(cmd)
   );

   pli_datapath u_dp (
      .clock(clock), .reset(reset), .item(req_item), .cmd(cmd),
      .status(status), .result(rsp_item)
   );
endmodule
`default_nettype wire

>>> hw/rtl/pli_datapath.sv
// ----------------------------------------------------------------------------
// pli_datapath
// Segment length by bit-serial square root, interpolation by a combined
// shift-add multiply and divide over both axes at once, running length and
// hit state.
// ----------------------------------------------------------------------------
`default_nettype none
module pli_datapath (
   input  wire                    clock,
   input  wire                    reset,
   input  pli_pkg::req_item_type  item,
   input  pli_pkg::cmd_type       cmd,
   output pli_pkg::status_type    status,
   output pli_pkg::rsp_item_type  result
);
   import pli_pkg::*;

   localparam int CW  = COORD_W;
   localparam int DW  = CW + 1;          // delta magnitude width
   localparam int RW  = DW + 1;          // root width
   localparam int SQW = 2 * RW;          // sum of squares
   localparam int RSTEPS = RW;
   localparam int CNTW = $clog2(RSTEPS + 1);
   localparam logic [DIST_W-1:0] LEN_MAX = '1;

   logic signed [CW-1:0] cur_x_ff, cur_y_ff, prev_x_ff, prev_y_ff;
   logic signed [CW-1:0] hit_x_ff, hit_y_ff;
   logic [DIST_W-1:0]    run_ff, dist_ff;
   logic                 hit_ff, first_ff, last_ff, neg_ff;
   logic [DW-1:0]        dx_ff, dy_ff;
   logic                 sx_ff, sy_ff;
   logic [SQW-1:0]       sq_ff;
   logic [RW+1:0]        sqr_ff;
   logic [RW-1:0]        root_ff;
   logic [CNTW-1:0]      cnt_ff;
   logic [DW-1:0]        qx_ff, qy_ff;
   logic [RW-1:0]        remx_ff, remy_ff;
   logic                 ndiv_ff;

   logic signed [CW:0]   dxs, dys;
   logic [RW+1:0]        sq_sh, trial;
   logic [DIST_W-1:0]    part;
   logic [RW+1:0]        part_s, seg1, seg2, tx, ty;
   logic                 spans;
   logic [DIST_W:0]      run_sum;

   assign dxs = $signed({cur_x_ff[CW-1], cur_x_ff}) - $signed({prev_x_ff[CW-1], prev_x_ff});
   assign dys = $signed({cur_y_ff[CW-1], cur_y_ff}) - $signed({prev_y_ff[CW-1], prev_y_ff});
   assign sq_sh   = {sqr_ff[RW-1:0], sq_ff[SQW-1:SQW-2]};
   assign trial   = {root_ff, 2'b01};
   assign part    = dist_ff - run_ff;
   assign spans   = !hit_ff && !neg_ff && (run_ff <= dist_ff)
                    && ({{(DIST_W){1'b0}}, root_ff} >= {{RW{1'b0}}, part});
   assign part_s  = (RW+2)'(part[RW-1:0]);
   assign seg1    = (RW+2)'(root_ff);
   assign seg2    = {1'b0, root_ff, 1'b0};
   assign tx      = {1'b0, remx_ff, 1'b0} + (dx_ff[DW-1] ? part_s : '0);
   assign ty      = {1'b0, remy_ff, 1'b0} + (dy_ff[DW-1] ? part_s : '0);
   assign run_sum = {1'b0, run_ff} + (DIST_W+1)'(root_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff <= '0; prev_y_ff <= '0; run_ff <= '0; dist_ff <= '0;
         hit_ff <= 1'b0; hit_x_ff <= '0; hit_y_ff <= '0; neg_ff <= 1'b0;
         first_ff <= 1'b0; last_ff <= 1'b0; ndiv_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            cur_x_ff <= item.vertex_x[CW-1:0];
            cur_y_ff <= item.vertex_y[CW-1:0];
            first_ff <= item.first_vertex;
            last_ff  <= item.last_vertex;
            if (item.first_vertex) begin
               dist_ff  <= item.target_distance;
               neg_ff   <= item.target_distance[DIST_W-1];
               run_ff   <= '0;
               hit_ff   <= item.target_distance[DIST_W-1];
               hit_x_ff <= item.vertex_x[CW-1:0];
               hit_y_ff <= item.vertex_y[CW-1:0];
            end
         end
         if (cmd.start_square) begin
            sx_ff <= dxs[CW];
            sy_ff <= dys[CW];
            dx_ff <= dxs[CW] ? DW'(-dxs) : DW'(dxs);
            dy_ff <= dys[CW] ? DW'(-dys) : DW'(dys);
            sqr_ff <= '0;
            root_ff <= '0;
            cnt_ff <= CNTW'(RSTEPS);
         end
         if (cmd.load_square) begin
            sq_ff <= SQW'(dx_ff * dx_ff) + SQW'(dy_ff * dy_ff);
         end
         if (cmd.sqrt_step) begin
            if (sq_sh >= trial) begin
               sqr_ff  <= sq_sh - trial;
               root_ff <= {root_ff[RW-2:0], 1'b1};
            end else begin
               sqr_ff  <= sq_sh;
               root_ff <= {root_ff[RW-2:0], 1'b0};
            end
            sq_ff  <= {sq_ff[SQW-3:0], 2'b00};
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (cmd.start_mult) begin
            ndiv_ff <= spans && root_ff != '0;
            if (spans && root_ff == '0) begin
               hit_ff <= 1'b1; hit_x_ff <= prev_x_ff; hit_y_ff <= prev_y_ff;
            end
            qx_ff <= '0; qy_ff <= '0;
            remx_ff <= '0; remy_ff <= '0;
            cnt_ff <= CNTW'(DW);
         end
         if (cmd.div_step) begin
            if (tx >= seg2) begin
               remx_ff <= RW'(tx - seg2);
               qx_ff   <= {qx_ff[DW-2:0], 1'b0} + DW'(2);
            end else if (tx >= seg1) begin
               remx_ff <= RW'(tx - seg1);
               qx_ff   <= {qx_ff[DW-2:0], 1'b0} + DW'(1);
            end else begin
               remx_ff <= RW'(tx);
               qx_ff   <= {qx_ff[DW-2:0], 1'b0};
            end
            if (ty >= seg2) begin
               remy_ff <= RW'(ty - seg2);
               qy_ff   <= {qy_ff[DW-2:0], 1'b0} + DW'(2);
            end else if (ty >= seg1) begin
               remy_ff <= RW'(ty - seg1);
               qy_ff   <= {qy_ff[DW-2:0], 1'b0} + DW'(1);
            end else begin
               remy_ff <= RW'(ty);
               qy_ff   <= {qy_ff[DW-2:0], 1'b0};
            end
            dx_ff  <= {dx_ff[DW-2:0], 1'b0};
            dy_ff  <= {dy_ff[DW-2:0], 1'b0};
            cnt_ff <= cnt_ff - 1'b1;
         end
         if (cmd.update) begin
            if (!first_ff) begin
               if (ndiv_ff) begin
                  hit_ff   <= 1'b1;
                  hit_x_ff <= sx_ff ? prev_x_ff - CW'(qx_ff) : prev_x_ff + CW'(qx_ff);
                  hit_y_ff <= sy_ff ? prev_y_ff - CW'(qy_ff) : prev_y_ff + CW'(qy_ff);
               end
               run_ff <= (run_sum[DIST_W] || run_sum[DIST_W-1:0] == LEN_MAX)
                         ? LEN_MAX : run_sum[DIST_W-1:0];
               ndiv_ff <= 1'b0;
            end
            prev_x_ff <= cur_x_ff;
            prev_y_ff <= cur_y_ff;
         end
      end
   end

   assign status.first     = first_ff;
   assign status.last      = last_ff;
   assign status.need_div  = ndiv_ff;
   assign status.sqrt_done = (cnt_ff == '0);
   assign status.div_done  = (cnt_ff == '0);

   always_comb begin
      result.total_length = run_ff;
      if (hit_ff) begin
         result.point_x     = hit_x_ff;
         result.point_y     = hit_y_ff;
         result.where_found = neg_ff ? WHERE_BEFORE : WHERE_ON;
      end else begin
         result.point_x     = prev_x_ff;
         result.point_y     = prev_y_ff;
         result.where_found = WHERE_PAST;
      end
   end
endmodule
`default_nettype wire

>>> hw/rtl/pli_ctrl.sv
// ----------------------------------------------------------------------------
// pli_ctrl
// Sequencer: load, square, root, multiply, divide, update, deliver.
// ----------------------------------------------------------------------------
`default_nettype none
module pli_ctrl (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 in_valid,
   output logic                in_take,
   output logic                out_valid,
   input  wire                 out_stall,
   input  pli_pkg::status_type status,
   output pli_pkg::cmd_type    cmd
);
   import pli_pkg::*;

   state_type state_ff, state_in;
   logic      sqz_ff, sqz_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sqz_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sqz_ff   <= sqz_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      sqz_in    = sqz_ff;
      cmd       = '0;
      in_take   = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_take = in_valid;
            if (in_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (status.first) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.start_square = 1'b1;
               sqz_in   = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            sqz_in = 1'b0;
            if (sqz_ff) begin
               cmd.load_square = 1'b1;
            end else if (status.sqrt_done) begin
               state_in = ST_MULT;
            end else begin
               cmd.sqrt_step = 1'b1;
            end
         end
         ST_MULT: begin
            cmd.start_mult = 1'b1;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (!status.need_div || status.div_done) begin
               state_in = ST_UPDATE;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in = status.last ? ST_OUT : ST_IDLE;
         end
         ST_OUT: begin
            out_valid = 1'b1;
            if (!out_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
endmodule
`default_nettype wire

>>> hw/rtl/pli_checker.sv
// ----------------------------------------------------------------------------
// pli_checker
// Port-level checks for the polyline block.
// ----------------------------------------------------------------------------
`default_nettype none
module pli_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_stall,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input pli_pkg::rsp_item_type rsp_item
);
   import pli_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("rsp item changed while stalled");
   a_no_take_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("req taken while rsp pending");
   a_where_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_item.where_found != 2'd3)
      else $error("bad where_found");
   a_gap: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("back to back take");
endmodule

bind polyline_length_and_interpolate pli_checker u_pli_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
);
`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the polyline length and interpolation block.
// ----------------------------------------------------------------------------
// A table of directed vertices comes first, then random polylines with
// some noise, and one polyline long enough to saturate the length.
// Every result is checked against a predictor of the block or against a
// typed expectation. Both channels idle at random. Once, the result side
// holds off for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import pli_pkg::*;

   localparam logic [DIST_W-1:0] LEN_SAT = {DIST_W{1'b1}};
   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fffffff;
   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh80000000;

   typedef struct {
      req_item_type item;
      bit           typed;
      rsp_item_type result;
   } row_type;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;

   polyline_length_and_interpolate i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item)
   );

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // predicted polyline state
   logic signed [COORD_W-1:0] last_x, last_y, hit_x, hit_y;
   logic [DIST_W-1:0]         length_sum;
   logic signed [DIST_W-1:0]  goal_dist;
   bit                        hit_known;

   rsp_item_type pending_points[$];
   int  mismatch_count = 0;
   bit  steady = 0;
   bit  hold_rsp = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("%0t: %s got %0h expected %0h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [63:0] seg_root(input logic [127:0] v);
      logic [63:0] r, c;
      r = 0;
      for (int b = 35; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (128'(c) * 128'(c) <= v) r = c;
      end
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] lerp(input logic signed [COORD_W-1:0] p0,
         input logic signed [COORD_W-1:0] p1, input logic [63:0] part, input logic [63:0] seg);
      longint      d;
      logic [63:0] m, off;
      d = longint'(p1) - longint'(p0);
      if (seg == 0) return p0;
      m = d < 0 ? 64'(-d) : 64'(d);
      off = 64'((128'(m) * 128'(part)) / 128'(seg));
      return d < 0 ? p0 - COORD_W'(off) : p0 + COORD_W'(off);
   endfunction

   function automatic bit predict_vertex(input req_item_type v, output rsp_item_type r);
      longint      dx, dy;
      logic [63:0] mx, my, seg, part;
      r = '0;
      if (v.first_vertex) begin
         goal_dist = v.target_distance;
         length_sum = 0;
         hit_known = 0;
         if (goal_dist < 0) begin
            hit_known = 1;
            hit_x = v.vertex_x;
            hit_y = v.vertex_y;
         end
      end else begin
         dx = longint'(v.vertex_x) - longint'(last_x);
         dy = longint'(v.vertex_y) - longint'(last_y);
         mx = dx < 0 ? 64'(-dx) : 64'(dx);
         my = dy < 0 ? 64'(-dy) : 64'(dy);
         seg = seg_root(128'(mx) * 128'(mx) + 128'(my) * 128'(my));
         if (!hit_known && length_sum <= goal_dist
               && seg >= 64'(goal_dist) - 64'(length_sum)) begin
            part = 64'(goal_dist) - 64'(length_sum);
            hit_known = 1;
            hit_x = lerp(last_x, v.vertex_x, part, seg);
            hit_y = lerp(last_y, v.vertex_y, part, seg);
         end
         if (seg >= 64'(LEN_SAT) || 64'(length_sum) > 64'(LEN_SAT) - seg)
            length_sum = LEN_SAT;
         else
            length_sum = length_sum + DIST_W'(seg);
      end
      last_x = v.vertex_x;
      last_y = v.vertex_y;
      if (!v.last_vertex) return 0;
      r.total_length = length_sum;
      if (hit_known) begin
         r.point_x = hit_x;
         r.point_y = hit_y;
         r.where_found = goal_dist < 0 ? WHERE_BEFORE : WHERE_ON;
      end else begin
         r.point_x = v.vertex_x;
         r.point_y = v.vertex_y;
         r.where_found = WHERE_PAST;
      end
      return 1;
   endfunction

   function automatic req_item_type vtx(input logic signed [COORD_W-1:0] x,
         input logic signed [COORD_W-1:0] y, input logic signed [DIST_W-1:0] d,
         input bit f, input bit l);
      req_item_type v;
      v.vertex_x = x;
      v.vertex_y = y;
      v.target_distance = d;
      v.first_vertex = f;
      v.last_vertex = l;
      return v;
   endfunction

   function automatic rsp_item_type point(input logic [DIST_W-1:0] len,
         input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
         input logic [WHERE_W-1:0] w);
      rsp_item_type r;
      r.total_length = len;
      r.point_x = x;
      r.point_y = y;
      r.where_found = w;
      return r;
   endfunction

   task automatic send(input req_item_type v, input bit typed, input rsp_item_type want);
      rsp_item_type r;
      while (!steady && $urandom_range(99) < 13) begin
         req_valid = 0;
         @(negedge clock);
      end
      req_valid = 1;
      req_item = v;
      do @(posedge clock); while (req_stall);
      if (predict_vertex(v, r)) pending_points.push_back(typed ? want : r);
      @(negedge clock);
      req_valid = 0;
   endtask

   task automatic send_random(input req_item_type v);
      send(v, 0, '0);
   endtask

   function automatic logic signed [COORD_W-1:0] near(input logic signed [COORD_W-1:0] c);
      return c + COORD_W'($signed($urandom_range(131072)) - 65536);
   endfunction

   // result side
   initial begin
      rsp_stall = 0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_stall = 1;
            repeat (400) @(negedge clock);
            hold_rsp = 0;
         end
         rsp_stall = !steady && $urandom_range(99) < 13;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_points.size() == 0) begin
            report("unexpected item", 64'(rsp_item), 0);
         end else begin
            rsp_item_type w;
            w = pending_points.pop_front();
            if (rsp_item.total_length !== w.total_length)
               report("total_length", 64'(rsp_item.total_length), 64'(w.total_length));
            if (rsp_item.point_x !== w.point_x)
               report("point_x", 64'(rsp_item.point_x), 64'(w.point_x));
            if (rsp_item.point_y !== w.point_y)
               report("point_y", 64'(rsp_item.point_y), 64'(w.point_y));
            if (rsp_item.where_found !== w.where_found)
               report("where_found", 64'(rsp_item.where_found), 64'(w.where_found));
         end
      end
   end

   initial begin
      #20ms;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      row_type      rows[$];
      int           sent, n;
      logic signed [COORD_W-1:0] x, y;
      logic signed [DIST_W-1:0]  d;
      bit           wide;

      reset = 1;
      req_valid = 0;
      req_item = '0;
      last_x = 0; last_y = 0; hit_x = 0; hit_y = 0;
      length_sum = 0; goal_dist = 0; hit_known = 0;
      repeat (5) @(negedge clock);
      reset = 0;

      // after reset: polyline from (0,0) with distance 0
      rows.push_back('{vtx(0, 0, 0, 0, 1), 1, point(0, 0, 0, WHERE_ON)});
      // single vertex, negative distance
      rows.push_back('{vtx(5, -7, -5, 1, 1), 1, point(0, 5, -7, WHERE_BEFORE)});
      // single vertex, distance 0
      rows.push_back('{vtx(C_MAX, C_MIN, 0, 1, 1), 1, point(0, C_MAX, C_MIN, WHERE_PAST)});
      // 3-4-5 path, point on the second segment
      rows.push_back('{vtx(0, 0, 1280, 1, 0), 0, '0});
      rows.push_back('{vtx(768, 0, 0, 0, 0), 0, '0});
      rows.push_back('{vtx(768, 1024, 0, 0, 1), 0, '0});
      // zero-length segment
      rows.push_back('{vtx(100, 100, 0, 1, 0), 0, '0});
      rows.push_back('{vtx(100, 100, 0, 0, 1), 1, point(0, 100, 100, WHERE_ON)});
      // extremes, distance past the end
      rows.push_back('{vtx(C_MIN, C_MIN, 40'sh7fffffffff, 1, 0), 0, '0});
      rows.push_back('{vtx(C_MAX, C_MAX, 0, 0, 1), 0, '0});
      // continue after a last vertex
      rows.push_back('{vtx(C_MIN, C_MAX, 0, 0, 1), 0, '0});
      // most negative distance
      rows.push_back('{vtx(C_MAX, C_MIN, 40'sh8000000000, 1, 0), 0, '0});
      rows.push_back('{vtx(0, 0, 0, 0, 1), 0, '0});
      // distance exactly at the end of the path
      rows.push_back('{vtx(0, 0, 2560, 1, 0), 0, '0});
      rows.push_back('{vtx(-1536, -2048, 0, 0, 1), 0, '0});
      // point inside a diagonal with negative steps
      rows.push_back('{vtx(1000, 1000, 333, 1, 0), 0, '0});
      rows.push_back('{vtx(-7000, 500, 0, 0, 0), 0, '0});
      rows.push_back('{vtx(-7000, 500, 0, 0, 1), 0, '0});

      foreach (rows[i]) send(rows[i].item, rows[i].typed, rows[i].result);
      sent = rows.size();

      hold_rsp = 1;
      while (sent < 1750) begin
         steady = sent > 700 && sent < 900;
         if ($urandom_range(99) < 10) begin
            send_random(vtx($urandom, $urandom, {$urandom, 8'($urandom)},
                            $urandom_range(1), $urandom_range(1)));
            sent++;
         end else if (sent > 1200 && sent < 1300) begin
            // long zigzag over the full range saturates the length
            send_random(vtx(C_MIN, C_MIN, {$urandom, 8'($urandom)}, 1, 0));
            for (int k = 1; k <= 200; k++)
               send_random(vtx(k % 2 ? C_MAX : C_MIN, k % 2 ? C_MAX : C_MIN, 0, 0, k == 200));
            sent += 201;
         end else begin
            n = $urandom_range(8, 1);
            wide = $urandom_range(99) < 15;
            x = $urandom;
            y = $urandom;
            case ($urandom_range(5))
               0: d = -DIST_W'($urandom_range(1000000)) - 1;
               1: d = 0;
               2: d = {$urandom, 8'($urandom)};
               default: d = DIST_W'($urandom_range(n * 100000));
            endcase
            for (int k = 0; k < n; k++) begin
               send_random(vtx(x, y, d, k == 0, k == n - 1));
               x = wide ? $urandom : near(x);
               y = wide ? $urandom : near(y);
               d = {$urandom, 8'($urandom)};
            end
            sent += n;
         end
      end
      steady = 0;

      while (pending_points.size() != 0) @(negedge clock);
      repeat (300) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire
